// ===== design/chisq_pkg.sv =====
// Package with shared types and constants of the chi-square distance block.
`timescale 1ns / 1ps
package chisq_pkg;

  localparam int unsigned MaxBins   = 1024;
  localparam int unsigned CountW    = 11;
  localparam int unsigned CountCap  = (MaxBins < 2047) ? MaxBins : 2047;
  localparam int unsigned AccW      = 48;
  localparam int unsigned DiffW     = 32;
  localparam int unsigned SqW       = 64;
  localparam int unsigned DenW      = 17;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = 2;

  localparam logic [1:0] RegScaleFirst  = 2'd0;
  localparam logic [1:0] RegScaleSecond = 2'd1;
  localparam logic [1:0] RegConstraints = 2'd2;

  // One classified pair, handed from the front part to the divider.
  typedef struct packed {
    logic [DiffW-1:0] diff;
    logic [DenW-1:0]  den;
    logic             empty;
    logic             last;
  } pair_t;

endpackage

// ===== design/chisq_front.sv =====
// Front part: takes bin pairs, scales them and forms the absolute difference.
`timescale 1ns / 1ps
module chisq_front import chisq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] scale_first_i,
  input  logic [15:0] scale_second_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] first_bin_i,
  input  logic [15:0] second_bin_i,
  input  logic        last_bin_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output pair_t       out_pair_o
);

  logic             s1_valid_q;
  logic [15:0]      b1_q, b2_q;
  logic             last_q;
  logic [DiffW-1:0] p1_q, p2_q;
  logic             s2_valid_q;
  pair_t            s2_q;
  logic             s2_ready, s1_ready;

  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      p1_q   <= scale_first_i * first_bin_i;
      p2_q   <= scale_second_i * second_bin_i;
      b1_q   <= first_bin_i;
      b2_q   <= second_bin_i;
      last_q <= last_bin_i;
    end
    if (s2_ready && s1_valid_q) begin
      s2_q.diff  <= (p1_q >= p2_q) ? (p1_q - p2_q) : (p2_q - p1_q);
      s2_q.den   <= {1'b0, b1_q} + {1'b0, b2_q};
      s2_q.empty <= (b1_q == 16'd0) && (b2_q == 16'd0);
      s2_q.last  <= last_q;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_pair_o  = s2_q;

endmodule

// ===== design/chisq_queue.sv =====
// Short queue between the front part and the back part.
`timescale 1ns / 1ps
module chisq_queue import chisq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  pair_t in_pair_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output pair_t out_pair_o
);

  pair_t          mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;
  logic             push, pop;

  assign in_ready_o  = cnt_q != QDepth[QPtrW:0];
  assign out_valid_o = cnt_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_pair_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + {{QPtrW{1'b0}}, push} - {{QPtrW{1'b0}}, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_pair_i;
  end

endmodule

// ===== design/chisq_back.sv =====
// Back part: squares, divides one quotient bit a cycle and accumulates.
`timescale 1ns / 1ps
module chisq_back import chisq_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    constraint_count_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pair_t         in_pair_i,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [63:0]   m_axis_tdata
);

  typedef enum logic [1:0] {StIdle, StSquare, StDiv, StAcc} state_e;

  state_e             state_q;
  logic [DiffW-1:0]   diff_q;
  logic [DenW-1:0]    den_q;
  logic               empty_q, last_q;
  logic [SqW-1:0]     sq_q;
  logic [DenW+16:0]   rem_q;
  logic [AccW-1:0]    quo_q;
  logic [5:0]         bit_q;
  logic [AccW-1:0]    acc_q;
  logic [CountW-1:0]  cnt_q;
  logic               sat_q;
  logic               ovalid_q;
  logic [60:0]        odata_q;
  logic [DenW+16:0]   rem_sh;
  logic [DenW+16:0]   dsor;
  logic [AccW:0]      sum;
  logic               acc_go;

  assign in_ready_o    = (state_q == StIdle);
  assign dsor          = {1'b0, den_q, 16'd0};
  assign rem_sh        = {rem_q[DenW+15:0], sq_q[SqW-1]};
  assign sum           = {1'b0, acc_q} + {1'b0, quo_q};
  assign acc_go        = (state_q == StAcc) && (!last_q || !ovalid_q || m_axis_tready);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {3'd0, odata_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      acc_q    <= '0;
      cnt_q    <= '0;
      sat_q    <= 1'b0;
      ovalid_q <= 1'b0;
      bit_q    <= '0;
    end else begin
      if (ovalid_q && m_axis_tready && !(acc_go && last_q)) ovalid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            diff_q  <= in_pair_i.diff;
            den_q   <= in_pair_i.den;
            empty_q <= in_pair_i.empty;
            last_q  <= in_pair_i.last;
            state_q <= in_pair_i.empty ? StAcc : StSquare;
          end
        end
        StSquare: begin
          sq_q    <= diff_q * diff_q;
          rem_q   <= '0;
          quo_q   <= '0;
          bit_q   <= 6'd63;
          state_q <= StDiv;
        end
        StDiv: begin
          if (rem_sh >= dsor) begin
            rem_q <= rem_sh - dsor;
            quo_q <= {quo_q[AccW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[AccW-2:0], 1'b0};
          end
          sq_q  <= {sq_q[SqW-2:0], 1'b0};
          bit_q <= bit_q - 1'b1;
          if (bit_q == 6'd0) state_q <= StAcc;
        end
        StAcc: begin
          if (acc_go) begin
            logic [AccW-1:0]   nacc;
            logic [CountW-1:0] ncnt;
            logic              nsat;
            nacc = acc_q;
            ncnt = cnt_q;
            nsat = sat_q;
            if (!empty_q) begin
              if (sum[AccW]) begin
                nacc = '1;
                nsat = 1'b1;
              end else begin
                nacc = sum[AccW-1:0];
              end
              if (ncnt < CountCap[CountW-1:0]) ncnt = ncnt + 1'b1;
            end
            if (last_q) begin
              odata_q  <= {nsat, {1'b0, ncnt} - {10'd0, constraint_count_i}, nacc};
              ovalid_q <= 1'b1;
              acc_q    <= '0;
              cnt_q    <= '0;
              sat_q    <= 1'b0;
            end else begin
              acc_q <= nacc;
              cnt_q <= ncnt;
              sat_q <= nsat;
            end
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== design/chi_square_two_histogram_distance_top.sv =====
// Top level of the chi-square distance block over two streamed histograms.
`timescale 1ns / 1ps
// A non-empty bin pair is squared and then divided by the one-bit-per-cycle
// restoring divider in the back part; an all-zero pair skips both. Until
// they fill, the front part and a four-entry queue keep taking beats while
// the divider works. One result beat leaves on each beat with tlast set.
module chi_square_two_histogram_distance_top import chisq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // first_bin, second_bin
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // chi_square, degrees_of_freedom, overflowed
);

  logic [15:0] scale_first_q, scale_second_q;
  logic [1:0]  constraint_q;
  logic        f_valid, f_ready, b_valid, b_ready;
  pair_t       f_pair, b_pair;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_first_q  <= 16'd4096;
      scale_second_q <= 16'd4096;
      constraint_q   <= 2'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegScaleFirst:  scale_first_q  <= cfg_data_i;
        RegScaleSecond: scale_second_q <= cfg_data_i;
        RegConstraints: constraint_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  chisq_front u_front (
    .clk_i, .rst_ni,
    .scale_first_i(scale_first_q), .scale_second_i(scale_second_q),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .first_bin_i(s_axis_tdata[15:0]), .second_bin_i(s_axis_tdata[31:16]),
    .last_bin_i(s_axis_tlast),
    .out_valid_o(f_valid), .out_ready_i(f_ready), .out_pair_o(f_pair)
  );

  chisq_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready), .in_pair_i(f_pair),
    .out_valid_o(b_valid), .out_ready_i(b_ready), .out_pair_o(b_pair)
  );

  chisq_back u_back (
    .clk_i, .rst_ni,
    .constraint_count_i(constraint_q),
    .in_valid_i(b_valid), .in_ready_o(b_ready), .in_pair_i(b_pair),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[63:61] == 3'd0)
    else $error("result padding not zero");
  a_queue_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid && !b_ready |=> b_valid)
    else $error("queue lost an entry");
`endif

endmodule
